>>> rtl/core/cfsfg_pkg.sv
// Shared types, constants and helpers for the click-free swap fade gate.
package cfsfg_pkg;

    // Sample width and padded stream data width
    localparam int SAMPLE_BITS = 24;
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

    // Gain format: unsigned Q1.15, 0x8000 is unity
    localparam int              GAIN_W          = 16;
    localparam logic [GAIN_W-1:0] UNITY_Q15     = 16'h8000;
    localparam logic [GAIN_W-1:0] FADE_STEP_RST = 16'd328;

    // Configuration port
    localparam int         APB_ADDR_W = 3;
    localparam int         APB_DATA_W = 32;
    localparam logic [0:0] REG_FADE_STEP = 1'b0;

    // Gate phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_FADE_OUT = 2'd1,
        PH_GAP      = 2'd2,
        PH_FADE_IN  = 2'd3
    } phase_t;

    // One input item as held in the input register
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   first;
        logic                   last;
        logic                   req;
    } item_t;

    // Control results for one item
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              gap;
        logic              swap;
        phase_t            phase;
    } ctrl_out_t;

    // Clamp the programmed step into 1 .. unity
    function automatic logic [GAIN_W-1:0] eff_step(input logic [GAIN_W-1:0] step);
        logic [GAIN_W-1:0] r;
        if (step == '0) begin
            r = {{(GAIN_W-1){1'b0}}, 1'b1};
        end else if (step > UNITY_Q15) begin
            r = UNITY_Q15;
        end else begin
            r = step;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/cfsfg_apb_regs.sv
// APB register file holding the fade step.
module cfsfg_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfsfg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cfsfg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cfsfg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [cfsfg_pkg::GAIN_W-1:0]        fade_step
);

    logic [cfsfg_pkg::GAIN_W-1:0] fade_step_reg;
    logic [cfsfg_pkg::GAIN_W-1:0] fade_step_next;
    logic                         wr_en;
    logic                         sel_step;

    // Decode the word address
    assign sel_step = (paddr[cfsfg_pkg::APB_ADDR_W-1:2] == cfsfg_pkg::REG_FADE_STEP);
    assign wr_en    = psel & penable & pwrite;
    assign pready   = 1'b1;

    // Take the write on the access phase
    always_comb begin
        fade_step_next = fade_step_reg;
        if (wr_en && sel_step) begin
            fade_step_next = pwdata[cfsfg_pkg::GAIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_step_reg <= cfsfg_pkg::FADE_STEP_RST;
        end else begin
            fade_step_reg <= fade_step_next;
        end
    end

    // Read back
    assign prdata = sel_step
        ? {{(cfsfg_pkg::APB_DATA_W-cfsfg_pkg::GAIN_W){1'b0}}, fade_step_reg}
        : '0;
    assign fade_step = fade_step_reg;

endmodule

>>> rtl/core/cfsfg_ctrl.sv
// Phase sequencer and gain ramp of the fade gate.
module cfsfg_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  cfsfg_pkg::item_t              item,
    input  logic [cfsfg_pkg::GAIN_W-1:0]  fade_step,
    output cfsfg_pkg::ctrl_out_t          ctrl
);

    cfsfg_pkg::phase_t            phase_reg, phase_next;
    logic [cfsfg_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic                         pend_reg, pend_next;
    logic                         gap_reg, gap_next;
    logic                         ramps_reg, ramps_next;

    // Intermediate values for the current item
    cfsfg_pkg::phase_t            ph_blk;
    logic                         pend_blk;
    logic                         gap_blk;
    logic                         ramps_blk;
    logic [cfsfg_pkg::GAIN_W-1:0] step;
    logic [cfsfg_pkg::GAIN_W:0]   gain_sum;
    logic [cfsfg_pkg::GAIN_W-1:0] gain_blk;

    assign step     = cfsfg_pkg::eff_step(fade_step);
    assign gain_sum = {1'b0, gain_reg} + {1'b0, step};

    // Decide block kind at block start and ramp the gain
    always_comb begin
        pend_blk  = pend_reg | item.req;
        ph_blk    = phase_reg;
        gap_blk   = gap_reg;
        ramps_blk = ramps_reg;
        if (item.first) begin
            gap_blk = (phase_reg == cfsfg_pkg::PH_GAP);
            if (phase_reg == cfsfg_pkg::PH_IDLE && pend_blk) begin
                pend_blk = 1'b0;
                ph_blk   = cfsfg_pkg::PH_FADE_OUT;
            end
            ramps_blk = (ph_blk inside {cfsfg_pkg::PH_FADE_OUT, cfsfg_pkg::PH_FADE_IN});
        end
        gain_blk = gain_reg;
        if (ramps_blk) begin
            case (ph_blk)
                cfsfg_pkg::PH_FADE_OUT: begin
                    gain_blk = (gain_reg > step) ? gain_reg - step : '0;
                end
                cfsfg_pkg::PH_FADE_IN: begin
                    gain_blk = (gain_sum >= {1'b0, cfsfg_pkg::UNITY_Q15})
                        ? cfsfg_pkg::UNITY_Q15 : gain_sum[cfsfg_pkg::GAIN_W-1:0];
                end
                default: begin
                    gain_blk = gain_reg;
                end
            endcase
        end
    end

    // Next state: advance the phase at block end
    always_comb begin
        phase_next = phase_reg;
        gain_next  = gain_reg;
        pend_next  = pend_reg;
        gap_next   = gap_reg;
        ramps_next = ramps_reg;
        if (advance) begin
            phase_next = ph_blk;
            gain_next  = gain_blk;
            pend_next  = pend_blk;
            gap_next   = gap_blk;
            ramps_next = ramps_blk;
            if (item.last) begin
                case (ph_blk)
                    cfsfg_pkg::PH_FADE_OUT: begin
                        if (gain_blk == '0) begin
                            phase_next = cfsfg_pkg::PH_GAP;
                        end
                    end
                    cfsfg_pkg::PH_FADE_IN: begin
                        if (gain_blk >= cfsfg_pkg::UNITY_Q15) begin
                            gain_next  = cfsfg_pkg::UNITY_Q15;
                            phase_next = cfsfg_pkg::PH_IDLE;
                        end
                    end
                    cfsfg_pkg::PH_GAP: begin
                        phase_next = cfsfg_pkg::PH_FADE_IN;
                    end
                    default: begin
                        phase_next = ph_blk;
                    end
                endcase
                gap_next   = 1'b0;
                ramps_next = 1'b0;
            end
        end
    end

    // Outputs for the current item
    always_comb begin
        ctrl.gain = gain_blk;
        ctrl.gap  = gap_blk;
        ctrl.swap = item.last & gap_blk;
        ctrl.phase = ph_blk;
        if (item.last) begin
            case (ph_blk)
                cfsfg_pkg::PH_FADE_OUT: begin
                    if (gain_blk == '0) begin
                        ctrl.phase = cfsfg_pkg::PH_GAP;
                    end
                end
                cfsfg_pkg::PH_FADE_IN: begin
                    if (gain_blk >= cfsfg_pkg::UNITY_Q15) begin
                        ctrl.phase = cfsfg_pkg::PH_IDLE;
                    end
                end
                cfsfg_pkg::PH_GAP: begin
                    ctrl.phase = cfsfg_pkg::PH_FADE_IN;
                end
                default: begin
                    ctrl.phase = ph_blk;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cfsfg_pkg::PH_IDLE;
            gain_reg  <= cfsfg_pkg::UNITY_Q15;
            pend_reg  <= 1'b0;
            gap_reg   <= 1'b0;
            ramps_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            gain_reg  <= gain_next;
            pend_reg  <= pend_next;
            gap_reg   <= gap_next;
            ramps_reg <= ramps_next;
        end
    end

    // Gain never rises above unity
    a_gain_max: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= cfsfg_pkg::UNITY_Q15)
        else $error("gate gain above unity");

    // The gap phase is only reached with the gain fully down
    a_gap_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == cfsfg_pkg::PH_GAP |-> gain_reg == '0)
        else $error("gap phase with nonzero gain");

    // A gap block lives only inside the gap phase
    a_gap_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_reg |-> phase_reg == cfsfg_pkg::PH_GAP)
        else $error("gap block outside gap phase");

    // A ramping block lives only in a fade phase
    a_ramp_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        ramps_reg |-> (phase_reg == cfsfg_pkg::PH_FADE_OUT ||
                       phase_reg == cfsfg_pkg::PH_FADE_IN))
        else $error("ramping block outside a fade phase");

    // The swap strobe always hands over to the fade-in
    a_swap_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctrl.swap |=> phase_reg == cfsfg_pkg::PH_FADE_IN)
        else $error("swap strobe without entering fade-in");

endmodule

>>> rtl/core/cfsfg_scale.sv
// Gain multiply with arithmetic shift and gap muting.
module cfsfg_scale (
    input  logic signed [cfsfg_pkg::SAMPLE_BITS-1:0] sample,
    input  logic        [cfsfg_pkg::GAIN_W-1:0]      gain,
    input  logic                                     mute,
    output logic signed [cfsfg_pkg::SAMPLE_BITS-1:0] result
);

    localparam int PROD_W = cfsfg_pkg::SAMPLE_BITS + cfsfg_pkg::GAIN_W + 1;

    logic signed [PROD_W-1:0]             prod;
    logic signed [cfsfg_pkg::GAIN_W:0]    gain_s;

    // Signed product, floor by shifting right 15; gain at most unity so it fits
    assign gain_s = $signed({1'b0, gain});
    assign prod   = sample * gain_s;
    assign result = mute ? '0 : prod[cfsfg_pkg::SAMPLE_BITS+14:15];

endmodule

>>> rtl/core/click_free_swap_fade_gate.sv
// Top level of the click-free swap fade gate.
//
// Gates a stream of audio samples so a downstream model can be swapped without
// a click. Input transfers carry one sample on s_tdata, the block end on
// s_tlast, and block start and swap request on s_tuser. Each input transfer
// yields exactly one output transfer: the gated sample on m_tdata, plus the
// swap strobe and the phase after the sample on m_tuser.
// The APB port holds the fade step (Q1.15 gain change per sample).
//
// m_tvalid rises once a sample has passed the input register and then the
// output register. One sample is accepted every cycle while the receiver does
// not stall: the input register feeds the phase and gain update plus one
// multiply, whose combinational results load the output register.
// When the receiver stalls, the output register holds its transfer and the
// input register takes one more sample before s_tready drops.
// Reset (aresetn low, synchronous) empties both registers, sets the gain to
// unity, the phase to idle, drops any pending swap request and loads the
// default fade step of 328.
module click_free_swap_fade_gate (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [cfsfg_pkg::TDATA_W-1:0]           s_tdata,  // [23:0] sample_in
    input  logic                                    s_tlast,  // last_in_block
    input  logic [1:0]                              s_tuser,  // [0] first_in_block, [1] swap_request
    // Output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [cfsfg_pkg::TDATA_W-1:0]           m_tdata,  // [23:0] sample_out
    output logic [2:0]                              m_tuser,  // [0] swap_now, [2:1] fade_phase
    // Configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [cfsfg_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [cfsfg_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [cfsfg_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                    pready
);

    localparam int SB = cfsfg_pkg::SAMPLE_BITS;

    logic                                in_vld_reg, in_vld_next;
    cfsfg_pkg::item_t                    in_item_reg, in_item_next;
    logic                                out_vld_reg, out_vld_next;
    logic signed [SB-1:0]                out_sample_reg, out_sample_next;
    logic                                out_swap_reg, out_swap_next;
    cfsfg_pkg::phase_t                   out_phase_reg, out_phase_next;

    logic                                out_free;
    logic                                advance;
    logic [cfsfg_pkg::GAIN_W-1:0]        fade_step;
    cfsfg_pkg::ctrl_out_t                ctrl;
    logic signed [SB-1:0]                scaled;

    // Handshake: output register free or draining this cycle
    assign out_free = ~out_vld_reg | m_tready;
    assign advance  = in_vld_reg & out_free;
    assign s_tready = ~in_vld_reg | out_free;

    cfsfg_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fade_step (fade_step)
    );

    cfsfg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (in_item_reg),
        .fade_step (fade_step),
        .ctrl      (ctrl)
    );

    cfsfg_scale u_scale (
        .sample (in_item_reg.sample),
        .gain   (ctrl.gain),
        .mute   (ctrl.gap),
        .result (scaled)
    );

    // Input register: load on each input transfer
    always_comb begin
        in_vld_next  = in_vld_reg;
        in_item_next = in_item_reg;
        if (s_tready) begin
            in_vld_next = s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_item_next.sample = s_tdata[SB-1:0];
            in_item_next.first  = s_tuser[0];
            in_item_next.last   = s_tlast;
            in_item_next.req    = s_tuser[1];
        end
    end

    // Output register: hold while stalled, load when the item advances
    always_comb begin
        out_vld_next    = out_vld_reg;
        out_sample_next = out_sample_reg;
        out_swap_next   = out_swap_reg;
        out_phase_next  = out_phase_reg;
        if (out_free) begin
            out_vld_next = in_vld_reg;
        end
        if (advance) begin
            out_sample_next = scaled;
            out_swap_next   = ctrl.swap;
            out_phase_next  = ctrl.phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg    <= in_item_next;
        out_sample_reg <= out_sample_next;
        out_swap_reg   <= out_swap_next;
        out_phase_reg  <= out_phase_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(cfsfg_pkg::TDATA_W-SB){1'b0}}, out_sample_reg};
    assign m_tuser  = {out_phase_reg, out_swap_reg};

endmodule
